// ===== rtl/core/dedup_move_to_front_list_assert.svh =====
// ----------------------------------------------------------------------------
// dedup_move_to_front_list_assert.svh
// assertion macros used by the move-to-front list checker
// ----------------------------------------------------------------------------
`ifndef DEDUP_MOVE_TO_FRONT_LIST_ASSERT_SVH
`define DEDUP_MOVE_TO_FRONT_LIST_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DMTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmtf_pkg
// item kinds, status codes and the result bundle of the move-to-front list
// ----------------------------------------------------------------------------
package dmtf_pkg;

  localparam int KEY_W   = 64;
  localparam int PAY_W   = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY_KEY = 2'd1;
  localparam logic [1:0] ST_BEYOND    = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic               was_present;
    logic [COUNT_W-1:0] entry_count;
    logic [KEY_W-1:0]   read_key;
    logic [PAY_W-1:0]   read_payload;
  } result_t;

endpackage

// ===== rtl/core/dmtf_ram.sv =====
// ----------------------------------------------------------------------------
// dmtf_ram
// simple dual-port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
module dmtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dmtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmtf_ctrl
// sequencer: search-and-shift pass over the list memories, front write,
// position read and result assembly
// ----------------------------------------------------------------------------
module dmtf_ctrl import dmtf_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    kind,
  input  logic [KEY_W-1:0]              entry_key,
  input  logic [PAY_W-1:0]              entry_payload,
  input  logic [POS_W-1:0]              position,
  input  logic                          out_free,
  output logic                          res_valid,
  output result_t                       res,
  output logic                          mem_we,
  output logic [$clog2(LIST_DEPTH)-1:0] mem_waddr,
  output logic [$clog2(LIST_DEPTH)-1:0] mem_raddr,
  output logic [KEY_W-1:0]              mem_wkey,
  output logic [PAY_W-1:0]              mem_wpay,
  input  logic [KEY_W-1:0]              mem_rkey,
  input  logic [PAY_W-1:0]              mem_rpay
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FRONT = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state;
  logic [1:0]       kind_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] payload_r;
  logic [POS_W-1:0] pos_r;
  logic [AW-1:0]    idx;
  logic             hit;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic          accept;
  logic          match;
  logic          at_tail;
  logic [AW-1:0] idx_inc;
  logic          pos_ok;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign match      = (mem_rkey == key_r);
  assign idx_inc    = idx + AW'(1);
  assign at_tail    = ((CW'(idx) + CW'(1)) == count);
  assign pos_ok     = (PW'(position) < PW'(count));

  // memory access
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wkey  = mem_rkey;
    mem_wpay  = mem_rpay;
    case (state)
      S_IDLE: begin
        if (kind == KIND_READ) begin
          mem_raddr = AW'(position);
        end
      end
      S_SCAN: begin
        // read ahead while the current entry shifts back one place
        mem_raddr = idx_inc;
        mem_waddr = idx_inc;
        mem_we    = !match && (idx != LAST_IDX);
      end
      S_FRONT: begin
        mem_we   = out_free;
        mem_wkey = key_r;
        mem_wpay = payload_r;
      end
      S_RDATA: begin
        mem_raddr = AW'(pos_r);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // result assembly
  always_comb begin
    count_next       = count;
    res_valid        = 1'b0;
    res.status       = ST_DONE;
    res.was_present  = 1'b0;
    res.read_key     = '0;
    res.read_payload = '0;
    case (state)
      S_FRONT: begin
        res_valid       = out_free;
        res.was_present = hit;
        if (!hit && (count != FULL_CNT)) begin
          count_next = count + CW'(1);
        end
      end
      S_RDATA: begin
        res_valid        = out_free;
        res.read_key     = mem_rkey;
        res.read_payload = mem_rpay;
      end
      S_FIN: begin
        res_valid = out_free;
        case (kind_r)
          KIND_RECORD: res.status = ST_EMPTY_KEY;
          KIND_READ:   res.status = ST_BEYOND;
          KIND_CLEAR:  count_next = '0;
          default:     res.status = ST_DONE;
        endcase
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res.entry_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_RECORD && entry_key != '0) begin
              state <= (count == '0) ? S_FRONT : S_SCAN;
            end else if (kind == KIND_READ && pos_ok) begin
              state <= S_RDATA;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (match || at_tail) begin
            state <= S_FRONT;
          end
        end
        S_FRONT, S_RDATA, S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind;
      key_r     <= entry_key;
      payload_r <= entry_payload;
      pos_r     <= position;
      idx       <= '0;
      hit       <= 1'b0;
    end else if (state == S_SCAN) begin
      if (match) begin
        hit <= 1'b1;
      end else begin
        idx <= idx_inc;
      end
    end
  end

endmodule

// ===== rtl/core/dedup_move_to_front_list.sv =====
// ----------------------------------------------------------------------------
// dedup_move_to_front_list
// bounded most-recent-first list of keyed entries with move-to-front on a
// repeated key, position read and clear
//
//   channel  | handshake                  | beat
//   item     | item_valid / item_ready    | kind, entry_key, entry_payload, position
//   result   | result_valid / result_ready| status, was_present, entry_count,
//            |                            | read_key, read_payload
//
// a record searches the stored entries: the key memory read port walks
// the list one entry per cycle, shifting back as it goes, then the new
// front entry is written. reset clears the count and the result valid
// flag; memories and the result fields are not cleared. a full result
// register stalls the last step of an item; a new item is still taken
// while a result waits.
// ----------------------------------------------------------------------------
module dedup_move_to_front_list import dmtf_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         kind,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [PAY_W-1:0]   entry_payload,
  input  logic [POS_W-1:0]   position,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         status,
  output logic               was_present,
  output logic [COUNT_W-1:0] entry_count,
  output logic [KEY_W-1:0]   read_key,
  output logic [PAY_W-1:0]   read_payload
);

  localparam int AW = $clog2(LIST_DEPTH);

  logic          out_free;
  logic          res_valid;
  result_t       res;
  result_t       res_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [KEY_W-1:0] mem_wkey;
  logic [KEY_W-1:0] mem_rkey;
  logic [PAY_W-1:0] mem_wpay;
  logic [PAY_W-1:0] mem_rpay;

  assign out_free = !result_valid || result_ready;

  dmtf_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .kind          (kind),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .position      (position),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .mem_wkey      (mem_wkey),
    .mem_wpay      (mem_wpay),
    .mem_rkey      (mem_rkey),
    .mem_rpay      (mem_rpay)
  );

  dmtf_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wkey),
    .raddr (mem_raddr),
    .rdata (mem_rkey)
  );

  dmtf_ram #(.WIDTH(PAY_W), .DEPTH(LIST_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wpay),
    .raddr (mem_raddr),
    .rdata (mem_rpay)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign was_present  = res_q.was_present;
  assign entry_count  = res_q.entry_count;
  assign read_key     = res_q.read_key;
  assign read_payload = res_q.read_payload;

endmodule

// ===== rtl/core/dmtf_checker.sv =====
// ----------------------------------------------------------------------------
// dmtf_checker
// port-level checks on the move-to-front list, bound to the top level
// ----------------------------------------------------------------------------
`include "dedup_move_to_front_list_assert.svh"

module dmtf_checker import dmtf_pkg::*; #(
  parameter int LIST_DEPTH = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [1:0]         status,
  input logic               was_present,
  input logic [COUNT_W-1:0] entry_count,
  input logic [KEY_W-1:0]   read_key,
  input logic [PAY_W-1:0]   read_payload
);

  logic                                    res_stall;
  logic                                    no_read_data;
  logic                                    read_zero;
  logic [2+1+COUNT_W+KEY_W+PAY_W-1:0]      res_bits;

  assign res_stall    = result_valid && !result_ready;
  assign no_read_data = result_valid && (status != ST_DONE || was_present);
  assign read_zero    = (read_key == '0) && (read_payload == '0);
  assign res_bits     = {status, was_present, entry_count, read_key, read_payload};

  // a stalled result beat holds
  `DMTF_ASSERT_NEXT(a_result_hold, res_stall, result_valid && $stable(res_bits), "stalled beat changed")

  // one item at a time: the block is busy right after taking a beat
  `DMTF_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "item taken while busy")

  `DMTF_ASSERT_SAME(a_count_bound, result_valid, (LIST_DEPTH > 63) || (entry_count <= LIST_DEPTH), "count above depth")

  // only a plain successful read carries entry data
  `DMTF_ASSERT_SAME(a_read_fields_zero, no_read_data, read_zero, "read fields set on non-read result")

endmodule

bind dedup_move_to_front_list dmtf_checker #(.LIST_DEPTH(LIST_DEPTH)) u_dmtf_checker (.*);
